// ----- rtl/sbpr_pkg.sv -----
package sbpr_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_RATE_FACTOR = 2'd0,
        REG_LOW_FREQ    = 2'd1,
        REG_LAG_COUNT   = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_index;

    // quarter-turn selection ahead of the cordic
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    localparam int RATE_W     = 32;
    localparam int FREQ_W     = 36;
    localparam int LAG_W      = 12;
    localparam int BIN_W      = 13;
    localparam int PERIOD_W   = 16;
    localparam int CFG_DATA_W = 36;
    localparam int CFG_IDX_W  = 2;

    localparam int CMP_W      = 20;   // bin / lag compare width
    localparam int DIFF_W     = 39;   // signed frequency difference
    localparam int DLO_W      = 20;   // low slice of the difference
    localparam int RP_W       = RATE_W + PERIOD_W + 1;
    localparam int PROD_W     = 60;   // phase product, 2^-60 turn units
    localparam int HI_KEEP_W  = PROD_W - DLO_W;
    localparam int ANG_W      = 32;
    localparam int Z_W        = 34;
    localparam int CORDIC_STEPS = 20;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int GUARD_SHIFT = 8;
    localparam int GAIN_SHIFT = 20;
    localparam logic [GAIN_SHIFT-1:0] INV_GAIN = 20'd636751;

    function automatic logic signed [Z_W-1:0] atan_turns(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            default: v = 32'h0;
        endcase
        return $signed({{(Z_W-32){1'b0}}, v});
    endfunction

endpackage

// ----- rtl/sbpr_if.sv -----
interface sbpr_in_if #(parameter int SAMPLE_BITS = 18);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
    logic [12:0]                   bin_index;
    logic [35:0]                   sky_freq;
    logic [15:0]                   period_index;
    logic                          last_in;
    modport source (output valid, sample_re, sample_im, bin_index, sky_freq,
                    period_index, last_in, input ready);
    modport sink   (input valid, sample_re, sample_im, bin_index, sky_freq,
                    period_index, last_in, output ready);
endinterface

interface sbpr_out_if #(parameter int SAMPLE_BITS = 18);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_re;
    logic signed [SAMPLE_BITS-1:0] out_im;
    logic [12:0]                   out_bin;
    logic                          last_out;
    modport source (output valid, out_re, out_im, out_bin, last_out, input ready);
    modport sink   (input valid, out_re, out_im, out_bin, last_out, output ready);
endinterface

interface sbpr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [35:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/spectrum_bin_phase_rotator.sv -----
// throughput: one sample per cycle; the pipeline advances whenever the
// output register is empty or its result is taken in the same cycle
// reset (synchronous, active low) empties the pipeline and sets rate_factor 0,
// low_freq 0, lag_count 1024
module spectrum_bin_phase_rotator #(
    parameter int MAX_LAGS    = 2048,
    parameter int SAMPLE_BITS = 18,
    parameter int PHASE_BITS  = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sbpr_in_if.sink    i_in,
    sbpr_out_if.source o_out,
    sbpr_cfg_if.sink   i_cfg
);
    import sbpr_pkg::*;

    // stage map: 0 offset/diff, 1 split multiply, 2 phase, 3 quarter turn,
    // 4..13 cordic (two steps each), 14 gain multiply, 15 output register
    localparam int NS   = 4 + CORDIC_STAGES + 2;
    localparam int XW   = SAMPLE_BITS + GUARD_SHIFT + 3;
    localparam int VW   = XW - GUARD_SHIFT;
    localparam int GW   = VW + GAIN_SHIFT + 2;
    localparam int RW   = GW - GAIN_SHIFT;

    // configuration registers
    logic signed [RATE_W-1:0] r_rate;
    logic [FREQ_W-1:0]        r_low;
    logic [LAG_W-1:0]         r_lag;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= '0;
            r_low  <= '0;
            r_lag  <= LAG_W'(1024);
        end else if (i_cfg.valid) begin
            unique case (t_reg_index'(i_cfg.index))
                REG_RATE_FACTOR: r_rate <= $signed(i_cfg.data[RATE_W-1:0]);
                REG_LOW_FREQ:    r_low  <= i_cfg.data[FREQ_W-1:0];
                REG_LAG_COUNT:   r_lag  <= i_cfg.data[LAG_W-1:0];
                REG_UNUSED:      ;
            endcase
        end
    end

    // global advance: the whole line moves unless the output is held
    logic w_en;
    logic r_v [NS];
    assign w_en       = !r_v[NS-1] || o_out.ready;
    assign i_in.ready = w_en;

    // sideband shift line, one slot per stage
    logic signed [SAMPLE_BITS-1:0] r_sre  [NS];
    logic signed [SAMPLE_BITS-1:0] r_sim  [NS];
    logic [BIN_W-1:0]              r_bin  [NS];
    logic                          r_last [NS];
    logic                          r_rot  [NS];

    // stage 0: bin decode, frequency difference, rate * period
    logic [CMP_W-1:0]         w_lags, w_k, w_lags3, w_lags4;
    logic                     w_lo_hit, w_hi_hit;
    logic signed [CMP_W-1:0]  w_off;
    logic signed [DIFF_W-1:0] w_d;
    logic signed [RP_W-1:0]   w_rp;

    always_comb begin
        w_lags   = (CMP_W'(r_lag) > CMP_W'(MAX_LAGS)) ? CMP_W'(MAX_LAGS) : CMP_W'(r_lag);
        w_k      = CMP_W'(i_in.bin_index);
        w_lags3  = (w_lags << 1) + w_lags;
        w_lags4  = w_lags << 2;
        w_lo_hit = (w_k >= CMP_W'(1)) && (w_k < w_lags);
        w_hi_hit = (w_k > w_lags3) && (w_k < w_lags4);
        w_off    = w_lo_hit ? $signed(w_k) : $signed(w_k - w_lags4);
        w_d      = $signed(DIFF_W'({1'b0, i_in.sky_freq}))
                 + ($signed(DIFF_W'(w_off)) <<< 16)
                 - $signed(DIFF_W'({1'b0, r_low}));
        w_rp     = r_rate * $signed({1'b0, i_in.period_index});
    end

    logic signed [RP_W-1:0]   r_rp;
    logic signed [DIFF_W-1:0] r_d;

    // stage 1: product mod 2^60 split over the difference
    logic signed [RP_W+DLO_W:0]         w_plo;
    logic signed [RP_W+DIFF_W-DLO_W-1:0] w_phi;
    assign w_plo = r_rp * $signed({1'b0, r_d[DLO_W-1:0]});
    assign w_phi = r_rp * $signed(r_d[DIFF_W-1:DLO_W]);

    logic [PROD_W-1:0]    r_plo;
    logic [HI_KEEP_W-1:0] r_phi;

    // stage 2: phase fraction, truncated
    logic [PROD_W-1:0] w_psum;
    assign w_psum = r_plo + {r_phi, {DLO_W{1'b0}}};

    logic [PHASE_BITS-1:0] r_ph;

    // stage 3: exact quarter turn, residual within an eighth turn
    logic [ANG_W-1:0]        w_ang, w_qsum;
    t_quad                   w_q;
    logic signed [XW-1:0]    w_xs, w_ys, w_x0, w_y0;
    logic signed [Z_W-1:0]   w_z0;

    always_comb begin
        w_ang  = {r_ph, {(ANG_W-PHASE_BITS){1'b0}}};
        w_qsum = w_ang + 32'h2000_0000;
        w_q    = t_quad'(w_qsum[ANG_W-1 -: 2]);
        w_z0   = Z_W'($signed(w_ang - {w_q, {(ANG_W-2){1'b0}}}));
        w_xs   = XW'(r_sre[2]);
        w_ys   = XW'(r_sim[2]);
        unique case (w_q)
            QUAD_0:   begin w_x0 = w_xs;  w_y0 = w_ys;  end
            QUAD_90:  begin w_x0 = -w_ys; w_y0 = w_xs;  end
            QUAD_180: begin w_x0 = -w_xs; w_y0 = -w_ys; end
            QUAD_270: begin w_x0 = w_ys;  w_y0 = -w_xs; end
        endcase
        w_x0 = w_x0 <<< GUARD_SHIFT;
        w_y0 = w_y0 <<< GUARD_SHIFT;
    end

    // cordic line, index 0 is the quarter-turn output
    logic signed [XW-1:0]  r_x [CORDIC_STAGES+1];
    logic signed [XW-1:0]  r_y [CORDIC_STAGES+1];
    logic signed [Z_W-1:0] r_z [CORDIC_STAGES+1];
    logic signed [XW-1:0]  w_xn [CORDIC_STAGES];
    logic signed [XW-1:0]  w_yn [CORDIC_STAGES];
    logic signed [Z_W-1:0] w_zn [CORDIC_STAGES];

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
        always_comb begin
            logic signed [XW-1:0]  x, y, dx, dy;
            logic signed [Z_W-1:0] z;
            x = r_x[s];
            y = r_y[s];
            z = r_z[s];
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                dx = y >>> (s*STEPS_PER_STAGE + j);
                dy = x >>> (s*STEPS_PER_STAGE + j);
                if (!z[Z_W-1]) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_turns(5'(s*STEPS_PER_STAGE + j));
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_turns(5'(s*STEPS_PER_STAGE + j));
                end
            end
            w_xn[s] = x;
            w_yn[s] = y;
            w_zn[s] = z;
        end
    end

    // gain stage: drop guard bits, times inverse gain, round half up
    logic signed [VW-1:0] w_vx, w_vy;
    logic signed [GW-1:0] w_gx, w_gy;
    assign w_vx = VW'(r_x[CORDIC_STAGES] >>> GUARD_SHIFT);
    assign w_vy = VW'(r_y[CORDIC_STAGES] >>> GUARD_SHIFT);
    assign w_gx = w_vx * $signed({1'b0, INV_GAIN})
                + $signed(GW'(1) <<< (GAIN_SHIFT-1));
    assign w_gy = w_vy * $signed({1'b0, INV_GAIN})
                + $signed(GW'(1) <<< (GAIN_SHIFT-1));

    logic signed [GW-1:0] r_gx, r_gy;

    // final: shift, saturate, bypass for unrotated samples
    localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (SAMPLE_BITS-1)) - 1);
    localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);
    logic signed [RW-1:0]          w_rx, w_ry;
    logic signed [SAMPLE_BITS-1:0] w_fx, w_fy, w_ore, w_oim;

    always_comb begin
        w_rx = RW'(r_gx >>> GAIN_SHIFT);
        w_ry = RW'(r_gy >>> GAIN_SHIFT);
        priority if (w_rx > SAT_HI) w_fx = SAMPLE_BITS'(SAT_HI);
        else if (w_rx < SAT_LO)     w_fx = SAMPLE_BITS'(SAT_LO);
        else                        w_fx = SAMPLE_BITS'(w_rx);
        priority if (w_ry > SAT_HI) w_fy = SAMPLE_BITS'(SAT_HI);
        else if (w_ry < SAT_LO)     w_fy = SAMPLE_BITS'(SAT_LO);
        else                        w_fy = SAMPLE_BITS'(w_ry);
        w_ore = r_rot[NS-2] ? w_fx : r_sre[NS-2];
        w_oim = r_rot[NS-2] ? w_fy : r_sim[NS-2];
    end

    logic signed [SAMPLE_BITS-1:0] r_ore, r_oim;

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < NS; n++) r_v[n] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_in.valid;
            for (int n = 1; n < NS; n++) r_v[n] <= r_v[n-1];
        end
    end

    // payload line, no reset
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sre[0]  <= i_in.sample_re;
            r_sim[0]  <= i_in.sample_im;
            r_bin[0]  <= i_in.bin_index;
            r_last[0] <= i_in.last_in;
            r_rot[0]  <= (w_lo_hit || w_hi_hit) && (r_rate != '0);
            for (int n = 1; n < NS; n++) begin
                r_sre[n]  <= r_sre[n-1];
                r_sim[n]  <= r_sim[n-1];
                r_bin[n]  <= r_bin[n-1];
                r_last[n] <= r_last[n-1];
                r_rot[n]  <= r_rot[n-1];
            end
            r_rp  <= w_rp;
            r_d   <= w_d;
            r_plo <= w_plo[PROD_W-1:0];
            r_phi <= w_phi[HI_KEEP_W-1:0];
            r_ph  <= w_psum[PROD_W-1 -: PHASE_BITS];
            r_x[0] <= w_x0;
            r_y[0] <= w_y0;
            r_z[0] <= w_z0;
            for (int s = 0; s < CORDIC_STAGES; s++) begin
                r_x[s+1] <= w_xn[s];
                r_y[s+1] <= w_yn[s];
                r_z[s+1] <= w_zn[s];
            end
            r_gx  <= w_gx;
            r_gy  <= w_gy;
            r_ore <= w_ore;
            r_oim <= w_oim;
        end
    end

    assign o_out.valid    = r_v[NS-1];
    assign o_out.out_re   = r_ore;
    assign o_out.out_im   = r_oim;
    assign o_out.out_bin  = r_bin[NS-1];
    assign o_out.last_out = r_last[NS-1];

`ifndef SYNTHESIS
    // residual angle after the quarter turn stays within an eighth turn
    a_residual_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] && r_rot[3] |->
            (r_z[0] <= $signed(Z_W'(32'h2000_0000))) &&
            (r_z[0] >= -$signed(Z_W'(32'h2000_0000))))
        else $error("cordic residual angle out of range");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result present after reset");

    // a held line keeps its valid bits
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v[NS-2]) && $stable(r_v[0]))
        else $error("valid bit moved during stall");

    // a zero sample stays zero whether rotated or not
    a_zero_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && r_sre[NS-1] == '0 && r_sim[NS-1] == '0 |->
            o_out.out_re == '0 && o_out.out_im == '0)
        else $error("zero sample not preserved");
`endif

endmodule
